// ----- rtl/ltsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ltsm_pkg
// Shared types and constants for the looping track stereo mixer.
// ----------------------------------------------------------------------------
package ltsm_pkg;

  // Item field widths
  localparam int MODE_W    = 2;
  localparam int TRACK_W   = 3;
  localparam int ADDR_W    = 12;
  localparam int SAMPLE_W  = 16;
  localparam int LENGTH_W  = 13;
  localparam int GAIN_W    = 16;

  // Signed sample times zero-extended unsigned gain
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

  // Parameter defaults
  localparam int DEF_NUM_TRACKS     = 8;
  localparam int DEF_MAX_SAMPLES    = 4096;
  localparam int DEF_GAIN_FRAC_BITS = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SETUP = 2'd1,
    MODE_PLAY  = 2'd2,
    MODE_MIX   = 2'd3
  } mode_t;

  // Command broadcast from the top level to every track cell
  typedef struct packed {
    logic                       load;
    logic                       setup;
    logic                       play;
    logic                       mix;
    logic [TRACK_W-1:0]         track;
    logic [ADDR_W-1:0]          address;
    logic [SAMPLE_W-1:0]        sample;
    logic [LENGTH_W-1:0]        length;
    logic [GAIN_W-1:0]          gain_left;
    logic [GAIN_W-1:0]          gain_right;
    logic                       run;
  } cmd_t;

endpackage

// ----- rtl/ltsm_if.sv -----
// ----------------------------------------------------------------------------
// ltsm_if
// Valid/ready channel interfaces for mixer items and mixed frames.
// ----------------------------------------------------------------------------
interface ltsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [ltsm_pkg::MODE_W-1:0]         mode;
  logic [ltsm_pkg::TRACK_W-1:0]        track;
  logic [ltsm_pkg::ADDR_W-1:0]         address;
  logic signed [ltsm_pkg::SAMPLE_W-1:0] sample;
  logic [ltsm_pkg::LENGTH_W-1:0]       length;
  logic [ltsm_pkg::GAIN_W-1:0]         gain_left;
  logic [ltsm_pkg::GAIN_W-1:0]         gain_right;
  logic                                run;

  modport source (output valid, mode, track, address, sample, length, gain_left,
                  gain_right, run, input ready);
  modport sink   (input valid, mode, track, address, sample, length, gain_left,
                  gain_right, run, output ready);
endinterface

interface ltsm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ltsm_pkg::SAMPLE_W-1:0] left;
  logic signed [ltsm_pkg::SAMPLE_W-1:0] right;
  logic                                 clipped;

  modport source (output valid, left, right, clipped, input ready);
  modport sink   (input valid, left, right, clipped, output ready);
endinterface

// ----- rtl/ltsm_cell.sv -----
// ----------------------------------------------------------------------------
// ltsm_cell
// One track: sample memory, loop state, gain multiply and one accumulate
// stage of the mix chain.
// ----------------------------------------------------------------------------
module ltsm_cell #(
  parameter int CELL_IDX    = 0,
  parameter int MAX_SAMPLES = ltsm_pkg::DEF_MAX_SAMPLES,
  parameter int ACC_W       = ltsm_pkg::PROD_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ltsm_pkg::cmd_t          cmd,
  input  logic                    sum_in_vld,
  input  logic signed [ACC_W-1:0] sum_in_l,
  input  logic signed [ACC_W-1:0] sum_in_r,
  output logic                    sum_out_vld,
  output logic signed [ACC_W-1:0] sum_out_l,
  output logic signed [ACC_W-1:0] sum_out_r
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int LW = $clog2(MAX_SAMPLES + 1);

  logic [ltsm_pkg::SAMPLE_W-1:0]     mem [MAX_SAMPLES];
  logic [ltsm_pkg::SAMPLE_W-1:0]     rd_data_r;
  logic [LW-1:0]                     len_r, len_nxt;
  logic [AW-1:0]                     pos_r, pos_nxt;
  logic                              act_r, act_nxt;
  logic [ltsm_pkg::GAIN_W-1:0]       gl_r, gr_r;
  logic                              en_r;
  logic signed [ltsm_pkg::PROD_W-1:0] prod_l_r, prod_r_r;
  logic                              vld_r;
  logic signed [ACC_W-1:0]           acc_l_r, acc_r_r;

  logic          sel;
  logic          live;
  logic [AW-1:0] eff_pos;
  logic [AW-1:0] adv_pos;

  assign sel  = (32'(cmd.track) == CELL_IDX);
  assign live = act_r && (len_r != '0);

  // Position wraps to zero if the length was lowered under it
  assign eff_pos = (32'(pos_r) >= 32'(len_r)) ? '0 : pos_r;
  assign adv_pos = (32'(eff_pos) + 32'd1 >= 32'(len_r)) ? '0 : AW'(32'(eff_pos) + 32'd1);

  always_comb begin
    len_nxt = len_r;
    pos_nxt = pos_r;
    act_nxt = act_r;
    if (cmd.setup && sel) begin
      len_nxt = (32'(cmd.length) > 32'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES) : LW'(cmd.length);
    end
    if (cmd.play && sel) begin
      act_nxt = cmd.run;
      if (cmd.run) begin
        pos_nxt = '0;
      end
    end
    if (cmd.mix && live) begin
      pos_nxt = adv_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= '0;
      act_r <= 1'b0;
      gl_r  <= '0;
      gr_r  <= '0;
      en_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      act_r <= act_nxt;
      if (cmd.setup && sel) begin
        gl_r <= cmd.gain_left;
        gr_r <= cmd.gain_right;
      end
      if (cmd.mix) begin
        en_r <= live;
      end
      vld_r <= sum_in_vld;
    end
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && sel) begin
      mem[AW'(cmd.address)] <= cmd.sample;
    end
    if (cmd.mix) begin
      rd_data_r <= mem[eff_pos];
    end
  end

  // Gain products, zero for an idle track
  always_ff @(posedge clk) begin
    if (en_r) begin
      prod_l_r <= $signed(rd_data_r) * $signed({1'b0, gl_r});
      prod_r_r <= $signed(rd_data_r) * $signed({1'b0, gr_r});
    end else begin
      prod_l_r <= '0;
      prod_r_r <= '0;
    end
  end

  // Chain stage: add this track into the running sums
  always_ff @(posedge clk) begin
    if (sum_in_vld) begin
      acc_l_r <= sum_in_l + ACC_W'(prod_l_r);
      acc_r_r <= sum_in_r + ACC_W'(prod_r_r);
    end
  end

  assign sum_out_vld = vld_r;
  assign sum_out_l   = acc_l_r;
  assign sum_out_r   = acc_r_r;

endmodule

// ----- rtl/looping_track_stereo_mixer.sv -----
// ----------------------------------------------------------------------------
// looping_track_stereo_mixer
// Looping multitrack sample player with a stereo gain mixer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command transactions: load a sample, set a track's length
//   and Q4.12 gains, play or stop a track, or mix one frame. out_ch carries
//   one stereo frame (left, right, clipped) per mix transaction; other modes
//   produce nothing.
//   Load, set-up and play/stop transactions are registered on acceptance and
//   may follow each other back to back.
//   A mix transaction reads every track memory in parallel, multiplies by the
//   gains, then passes a pair of running sums down the row of track cells,
//   one cell per cycle. The frame is rounded and registered for out_ch when
//   it leaves the last cell; in_ch is held off until then, so a new mix is
//   accepted only after the last one has left the accumulate chain.
//   The output register holds a frame while out_ch is stalled; a following
//   mix completes its chain and waits until the frame is taken.
//   Reset clears lengths, positions, gains and active flags and empties the
//   output. Sample memories are not cleared: load before playing.
//   Sums are exact; rounding is half up, then saturated to 16 bits.
// ----------------------------------------------------------------------------
module looping_track_stereo_mixer #(
  parameter int NUM_TRACKS     = ltsm_pkg::DEF_NUM_TRACKS,
  parameter int MAX_SAMPLES    = ltsm_pkg::DEF_MAX_SAMPLES,
  parameter int GAIN_FRAC_BITS = ltsm_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  ltsm_in_if.sink    in_ch,
  ltsm_out_if.source out_ch
);

  // Exact sum of NUM_TRACKS products
  localparam int ACC_W = ltsm_pkg::PROD_W + $clog2(NUM_TRACKS);
  localparam int SW    = ltsm_pkg::SAMPLE_W;

  localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W+1)'(1) <<< (GAIN_FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] SAT_LO   = (ACC_W+1)'(-32768);

  ltsm_pkg::cmd_t cmd;

  logic in_acc;
  logic mix_acc;
  logic busy_r, busy_nxt;
  logic go1_r, go2_r;
  logic pend_r, pend_nxt;
  logic res_rdy;
  logic move;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]    out_left_r, out_right_r;
  logic                    out_clip_r;
  logic [SW:0]             res_l, res_r;

  // Running sums between cells; entry 0 seeds the chain
  logic                    lnk_vld [NUM_TRACKS+1];
  logic signed [ACC_W-1:0] lnk_l   [NUM_TRACKS+1];
  logic signed [ACC_W-1:0] lnk_r   [NUM_TRACKS+1];

  // Round half up to Q1.15 and saturate; bit SW flags saturation
  function automatic logic [SW:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] q;
    logic [SW:0]           res;
    v = (ACC_W+1)'(acc) + HALF_LSB;
    q = v >>> GAIN_FRAC_BITS;
    if (q > SAT_HI) begin
      res = {1'b1, SAT_HI[SW-1:0]};
    end else if (q < SAT_LO) begin
      res = {1'b1, SAT_LO[SW-1:0]};
    end else begin
      res = {1'b0, q[SW-1:0]};
    end
    return res;
  endfunction

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign mix_acc     = in_acc && (in_ch.mode == ltsm_pkg::MODE_MIX);

  // Broadcast command to the cells; out-of-range addresses drop the write
  always_comb begin
    cmd            = '0;
    cmd.load       = in_acc && (in_ch.mode == ltsm_pkg::MODE_LOAD) &&
                     (32'(in_ch.address) < 32'(MAX_SAMPLES));
    cmd.setup      = in_acc && (in_ch.mode == ltsm_pkg::MODE_SETUP);
    cmd.play       = in_acc && (in_ch.mode == ltsm_pkg::MODE_PLAY);
    cmd.mix        = mix_acc;
    cmd.track      = in_ch.track;
    cmd.address    = in_ch.address;
    cmd.sample     = in_ch.sample;
    cmd.length     = in_ch.length;
    cmd.gain_left  = in_ch.gain_left;
    cmd.gain_right = in_ch.gain_right;
    cmd.run        = in_ch.run;
  end

  assign lnk_vld[0] = go2_r;
  assign lnk_l[0]   = '0;
  assign lnk_r[0]   = '0;

  for (genvar g = 0; g < NUM_TRACKS; g++) begin : g_cell
    ltsm_cell #(
      .CELL_IDX    (g),
      .MAX_SAMPLES (MAX_SAMPLES),
      .ACC_W       (ACC_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .sum_in_vld  (lnk_vld[g]),
      .sum_in_l    (lnk_l[g]),
      .sum_in_r    (lnk_r[g]),
      .sum_out_vld (lnk_vld[g+1]),
      .sum_out_l   (lnk_l[g+1]),
      .sum_out_r   (lnk_r[g+1])
    );
  end

  // Last cell holds its sums until the frame moves to the output register
  assign res_rdy = lnk_vld[NUM_TRACKS] || pend_r;
  assign move    = res_rdy && (!out_valid_r || out_ch.ready);
  assign res_l   = rnd_sat(lnk_l[NUM_TRACKS]);
  assign res_r   = rnd_sat(lnk_r[NUM_TRACKS]);

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = res_rdy && !move;
    out_valid_nxt = out_valid_r;
    if (mix_acc) begin
      busy_nxt = 1'b1;
    end
    if (move) begin
      busy_nxt = 1'b0;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      go1_r       <= 1'b0;
      go2_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      go1_r       <= mix_acc;
      go2_r       <= go1_r;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_left_r  <= res_l[SW-1:0];
      out_right_r <= res_r[SW-1:0];
      out_clip_r  <= res_l[SW] || res_r[SW];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.left    = out_left_r;
  assign out_ch.right   = out_right_r;
  assign out_ch.clipped = out_clip_r;

endmodule

// ----- rtl/ltsm_chk.sv -----
// ----------------------------------------------------------------------------
// ltsm_chk
// Port-level checks for the looping track stereo mixer.
// ----------------------------------------------------------------------------
module ltsm_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [ltsm_pkg::MODE_W-1:0]           in_mode,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [ltsm_pkg::SAMPLE_W-1:0]  out_left,
  input logic signed [ltsm_pkg::SAMPLE_W-1:0]  out_right,
  input logic                                  out_clipped
);

  logic in_acc;
  logic l_edge, r_edge;

  assign in_acc = in_valid && in_ready;
  assign l_edge = (out_left == 16'sh7FFF) || (out_left == -16'sh8000);
  assign r_edge = (out_right == 16'sh7FFF) || (out_right == -16'sh8000);

  // Stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
    $stable(out_right) && $stable(out_clipped))
    else $error("frame changed while stalled");

  // An accepted mix transaction deasserts input ready
  a_mix_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == ltsm_pkg::MODE_MIX) |=> !in_ready)
    else $error("input ready during mix");

  // Non-mix transactions never raise a frame
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_acc && (in_mode != ltsm_pkg::MODE_MIX) |=> !out_valid)
    else $error("frame without mix");

  // Clip flag only with a channel at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> l_edge || r_edge)
    else $error("clip flag without saturated channel");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind looping_track_stereo_mixer ltsm_chk u_ltsm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.mode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_left    (out_ch.left),
  .out_right   (out_ch.right),
  .out_clipped (out_ch.clipped)
);

// ----- verif/looping_track_stereo_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// looping_track_stereo_mixer_tb
// Self-checking bench for the looping track stereo mixer: a directed table of
// load, set-up, play/stop and mix transactions, then random track episodes and
// noise. Frames are checked against an in-bench track mixer predictor or typed frames.
// ----------------------------------------------------------------------------
module looping_track_stereo_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltsm_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int NUM_TRK     = DEF_NUM_TRACKS;
  localparam int MAX_SMP     = DEF_MAX_SAMPLES;
  localparam int FRAC        = DEF_GAIN_FRAC_BITS;
  // Drain time at the end to watch for stray frames, scaled by the track count.
  localparam int DRAIN       = 4 * (NUM_TRK + 3);

  typedef struct {
    mode_t               mode;
    logic [TRACK_W-1:0]  track;
    logic [ADDR_W-1:0]   address;
    logic [SAMPLE_W-1:0] sample;
    logic [LENGTH_W-1:0] length;
    logic [GAIN_W-1:0]   gain_left;
    logic [GAIN_W-1:0]   gain_right;
    logic                run;
  } mixer_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       clipped;
  } stereo_frame_t;

  // One stimulus row; 'typed' marks a frame written out by hand.
  typedef struct {
    mixer_item_t   item;
    bit            typed;
    stereo_frame_t frame;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ltsm_in_if  in_ch ();
  ltsm_out_if out_ch ();

  looping_track_stereo_mixer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state. bit types start at zero, which is the post-reset state
  // of lengths, positions, gains and play flags.
  // --------------------------------------------------------------------------
  bit [SAMPLE_W-1:0] pcm_mem     [NUM_TRK][MAX_SMP];
  bit                pcm_written [NUM_TRK][MAX_SMP];
  bit [LENGTH_W-1:0] loop_len    [NUM_TRK];
  bit [ADDR_W-1:0]   play_pos    [NUM_TRK];
  bit                playing     [NUM_TRK];
  bit [GAIN_W-1:0]   gain_l      [NUM_TRK];
  bit [GAIN_W-1:0]   gain_r      [NUM_TRK];

  stereo_frame_t frames_due[$];   // frames owed by accepted mix transactions
  stim_row_t     dir_rows[$];
  int            errors     = 0;
  int            items_sent = 0;
  int            src_idle   = 0;  // percent of cycles the sender holds off
  int            snk_idle   = 0;  // percent of cycles the receiver stalls

  // Round the exact Q.(15+FRAC) sum half up, then saturate to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc,
                                                            inout bit clip);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > 32767) begin
      clip = 1'b1;
      return 16'h7FFF;
    end
    if (q < -32768) begin
      clip = 1'b1;
      return 16'h8000;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // Apply one transaction to the predictor; returns 1 when a frame is due.
  function automatic bit track_mixer_step(input mixer_item_t it,
                                          output stereo_frame_t fr);
    longint acc_l, acc_r, smp;
    int     len, pos;
    bit     clip;
    acc_l = 0;
    acc_r = 0;
    clip  = 1'b0;
    fr.left    = '0;
    fr.right   = '0;
    fr.clipped = 1'b0;
    if (it.mode != MODE_MIX) begin
      if (int'(it.track) >= NUM_TRK) return 1'b0;
      case (it.mode)
        MODE_LOAD: begin
          if (int'(it.address) < MAX_SMP) begin
            pcm_mem[it.track][it.address]     = it.sample;
            pcm_written[it.track][it.address] = 1'b1;
          end
        end
        MODE_SETUP: begin
          loop_len[it.track] = LENGTH_W'((int'(it.length) > MAX_SMP) ? MAX_SMP
                                                                      : int'(it.length));
          gain_l[it.track]   = it.gain_left;
          gain_r[it.track]   = it.gain_right;
        end
        default: begin
          if (it.run) begin
            play_pos[it.track] = '0;
            playing[it.track]  = 1'b1;
          end else begin
            playing[it.track] = 1'b0;
          end
        end
      endcase
      return 1'b0;
    end
    for (int t = 0; t < NUM_TRK; t++) begin
      len = loop_len[t];
      pos = play_pos[t];
      // stopped or empty tracks add nothing and keep their position
      if (!playing[t] || len == 0) continue;
      // length lowered under the position: restart from zero
      if (pos >= len) pos = 0;
      smp = longint'($signed(pcm_mem[t][pos]));
      acc_l += smp * longint'(gain_l[t]);
      acc_r += smp * longint'(gain_r[t]);
      pos++;
      if (pos >= len) pos = 0;
      play_pos[t] = ADDR_W'(pos);
    end
    fr.left    = round_clip(acc_l, clip);
    fr.right   = round_clip(acc_r, clip);
    fr.clipped = clip;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Row builders. Fields a mode does not use carry random values.
  // --------------------------------------------------------------------------
  function automatic stim_row_t any_fields(input mode_t m);
    stim_row_t r;
    r.item.mode       = m;
    r.item.track      = TRACK_W'($urandom_range(0, NUM_TRK - 1));
    r.item.address    = ADDR_W'($urandom_range(0, MAX_SMP - 1));
    r.item.sample     = SAMPLE_W'($urandom_range(0, 16'hFFFF));
    r.item.length     = LENGTH_W'($urandom_range(0, 13'h1FFF));
    r.item.gain_left  = GAIN_W'($urandom_range(0, 16'hFFFF));
    r.item.gain_right = GAIN_W'($urandom_range(0, 16'hFFFF));
    r.item.run        = 1'($urandom_range(0, 1));
    r.typed           = 1'b0;
    r.frame.left      = '0;
    r.frame.right     = '0;
    r.frame.clipped   = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t ld(input int t, input int a, input int s);
    stim_row_t r;
    r = any_fields(MODE_LOAD);
    r.item.track   = TRACK_W'(t);
    r.item.address = ADDR_W'(a);
    r.item.sample  = SAMPLE_W'(s);
    return r;
  endfunction

  function automatic stim_row_t su(input int t, input int n, input int gl, input int gr);
    stim_row_t r;
    r = any_fields(MODE_SETUP);
    r.item.track      = TRACK_W'(t);
    r.item.length     = LENGTH_W'(n);
    r.item.gain_left  = GAIN_W'(gl);
    r.item.gain_right = GAIN_W'(gr);
    return r;
  endfunction

  function automatic stim_row_t pl(input int t, input bit go);
    stim_row_t r;
    r = any_fields(MODE_PLAY);
    r.item.track = TRACK_W'(t);
    r.item.run   = go;
    return r;
  endfunction

  function automatic stim_row_t mx();
    return any_fields(MODE_MIX);
  endfunction

  function automatic stim_row_t mx_exp(input int l, input int r, input bit c);
    stim_row_t row;
    row = any_fields(MODE_MIX);
    row.typed         = 1'b1;
    row.frame.left    = SAMPLE_W'(l);
    row.frame.right   = SAMPLE_W'(r);
    row.frame.clipped = c;
    return row;
  endfunction

  // Gains: mostly quiet so sums stay in range, some full scale.
  function automatic int rand_gain();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 16'h0800);
      2:       return $urandom_range(0, 16'h2000);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: fields change at the falling edge, acceptance is seen at
  // the rising edge. The expected frame is queued at the next falling edge,
  // well ahead of the earliest possible output.
  // --------------------------------------------------------------------------
  task automatic send_item(input stim_row_t row);
    stereo_frame_t fr;
    bit            due;
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode       = row.item.mode;
    in_ch.track      = row.item.track;
    in_ch.address    = row.item.address;
    in_ch.sample     = row.item.sample;
    in_ch.length     = row.item.length;
    in_ch.gain_left  = row.item.gain_left;
    in_ch.gain_right = row.item.gain_right;
    in_ch.run        = row.item.run;
    in_ch.valid      = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = track_mixer_step(row.item, fr);
    @(negedge clk);
    if (due) frames_due.push_back(row.typed ? row.frame : fr);
    items_sent++;
  endtask

  // A mix must never read a sample that was never loaded: load any entry the
  // coming frame would touch first, then mix.
  task automatic send_mix();
    int pos;
    for (int t = 0; t < NUM_TRK; t++) begin
      if (playing[t] && loop_len[t] != 0) begin
        pos = (int'(play_pos[t]) >= int'(loop_len[t])) ? 0 : int'(play_pos[t]);
        if (!pcm_written[t][pos]) send_item(ld(t, pos, $urandom_range(0, 16'hFFFF)));
      end
    end
    send_item(mx());
  endtask

  // Random traffic until the running transaction count reaches 'upto'.
  // Mostly well-formed episodes (set up, play, mix a few frames), the rest
  // single transactions with fully random fields.
  task automatic run_random(input int upto);
    int        trk, len;
    stim_row_t row;
    while (items_sent < upto) begin
      if ($urandom_range(0, 9) < 6) begin
        trk = $urandom_range(0, NUM_TRK - 1);
        // short loops so wrap-around shows up; now and then any length,
        // over-size ones included
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13'h1FFF)
                                          : $urandom_range(1, 12);
        send_item(su(trk, len, rand_gain(), rand_gain()));
        if ($urandom_range(0, 3) != 0) send_item(pl(trk, 1'b1));
        repeat ($urandom_range(1, 5)) send_mix();
        if ($urandom_range(0, 3) == 0) send_item(pl(trk, 1'b0));
      end else begin
        row = any_fields(mode_t'($urandom_range(0, 3)));
        if (row.item.mode == MODE_MIX) send_mix();
        else send_item(row);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, frame check at the rising edge.
  // --------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);

  always @(posedge clk) begin : frame_check
    stereo_frame_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (frames_due.size() == 0) begin
        $error("frame transaction with none expected: left %0d right %0d clipped %0b",
               out_ch.left, out_ch.right, out_ch.clipped);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (out_ch.left !== want.left) begin
          $error("left: expected %0d, got %0d", want.left, out_ch.left);
          errors++;
        end
        if (out_ch.right !== want.right) begin
          $error("right: expected %0d, got %0d", want.right, out_ch.right);
          errors++;
        end
        if (out_ch.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_ch.clipped);
          errors++;
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_LOAD;
    in_ch.track      = '0;
    in_ch.address    = '0;
    in_ch.sample     = '0;
    in_ch.length     = '0;
    in_ch.gain_left  = '0;
    in_ch.gain_right = '0;
    in_ch.run        = 1'b0;

    // Directed rows. Typed frames: Q4.12 gain 0x1000 is unity, 0x0800 half.
    dir_rows = '{
      mx_exp(0, 0, 0),                 // nothing set up after reset
      ld(0, 0, 32767),
      ld(0, 1, -32768),
      ld(0, 4095, -1),                 // top address
      su(0, 2, 'h1000, 'h1000),
      mx_exp(0, 0, 0),                 // track set up but stopped
      pl(0, 1'b1),
      mx_exp(32767, 32767, 0),         // full scale positive, no clip
      mx_exp(-32768, -32768, 0),       // full scale negative, exact, no clip
      su(0, 8191, 'hFFFF, 0),          // over-size length saturates
      mx_exp(32767, 0, 1),             // wrapped back to 0, left clips
      ld(0, 2, 'h1234),
      su(0, 1, 'h1000, 'hFFFF),        // length now under the position
      mx(),
      ld(7, 0, -32768),
      su(7, 1, 'hFFFF, 'hFFFF),
      pl(7, 1'b1),
      mx(),                            // two tracks summed
      pl(0, 1'b0),
      mx_exp(-32768, -32768, 1),       // negative saturation
      su(7, 0, 0, 0),                  // active but empty
      mx_exp(0, 0, 0),
      ld(7, 0, -1),
      su(7, 1, 'h0800, 'h1800),
      mx_exp(0, -1, 0)                 // ties -0.5 and -1.5 round upward
    };

    src_idle = 27;
    snk_idle = 53;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    run_random(150);

    src_idle = 53;
    snk_idle = 27;
    run_random(300);

    src_idle = 0;
    snk_idle = 0;
    run_random(425);

    in_ch.valid = 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    // keep watching for stray frames
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
